>>> rtl/ffsa_pkg.sv
// shared types and codes for the first-fit aligned suballocator
// no dependencies
package ffsa_pkg;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] req_size;
    logic [31:0] req_align;
    logic [31:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] part_offset;
  } rsp_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
  } entry_t;

  // request and reply of the remainder unit
  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [31:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } mod_rsp_t;

endpackage

>>> rtl/ffsa_mem.sv
// part table storage: one write port, one read port, registered read data
// depends on ffsa_pkg for the entry type
module ffsa_mem #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  ffsa_pkg::entry_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output ffsa_pkg::entry_t         rdata
);

  ffsa_pkg::entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ffsa_mod.sv
// bit-serial restoring remainder: 33-bit dividend by 32-bit divisor
// depends on ffsa_pkg for the request and reply structs
module ffsa_mod (
  input  logic               clk,
  input  logic               rst_n,
  input  ffsa_pkg::mod_req_t req,
  output ffsa_pkg::mod_rsp_t rsp
);

  logic [32:0] dvd_r, dvd_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  // one quotient bit per cycle
  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[32]};
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 32'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[31:0];
      end
      dvd_nxt = {dvd_r[31:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

>>> rtl/first_fit_aligned_suballocator.sv
// top level of the first-fit aligned suballocator: sequencer over the part table
// depends on ffsa_pkg, ffsa_mem and ffsa_mod
//
// One request is handled at a time. An allocate walks the sorted part table
// gap by gap. Each gap runs the serial remainder unit for the alignment
// rounding and one table read; the gap before the capacity runs the remainder
// unit only. Inserting shifts the entries above the new one up by one, a read
// state and a write state per moved entry, through the separate read and write
// ports of the table memory. Then the insert state writes the new part and the
// done state finishes. An allocate that appends to a table of 63 parts is the
// worst case. A free sweeps the whole table once, a read state and a check
// state per entry, compacting it in place. A full table goes from idle
// straight to the done state, which registers the result once the output is
// free. The result sits in an output register until taken, and the next beat
// is accepted only once the block is back in idle.
module first_fit_aligned_suballocator #(
  parameter int MAX_PARTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffsa_pkg::req_t     in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ffsa_pkg::rsp_t     out_data,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  localparam int AW = $clog2(MAX_PARTS);
  localparam int CW = $clog2(MAX_PARTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_PARTS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RND  = 4'd1;
  localparam logic [3:0] S_MODW = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_SHR  = 4'd4;
  localparam logic [3:0] S_SHW  = 4'd5;
  localparam logic [3:0] S_INS  = 4'd6;
  localparam logic [3:0] S_FRD  = 4'd7;
  localparam logic [3:0] S_FCK  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [31:0] cap_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic        hit_r, hit_nxt;
  logic        kind_r, kind_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] align_r, align_nxt;
  logic [31:0] foff_r, foff_nxt;
  logic [32:0] prev_end_r, prev_end_nxt;
  logic [33:0] cand_r, cand_nxt;
  ffsa_pkg::rsp_t res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  ffsa_pkg::rsp_t out_data_r, out_data_nxt;

  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  ffsa_pkg::entry_t mem_wdata;
  logic [AW-1:0] mem_raddr;
  ffsa_pkg::entry_t mem_rdata;

  ffsa_pkg::mod_req_t mod_req;
  ffsa_pkg::mod_rsp_t mod_rsp;

  logic [33:0] rounded;
  logic [34:0] fit_end;

  ffsa_mem #(.DEPTH(MAX_PARTS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffsa_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // round the previous end up to the alignment; zero stays zero
  always_comb begin
    if (prev_end_r == 33'd0 || mod_rsp.rem == 32'd0) begin
      rounded = {1'b0, prev_end_r};
    end else begin
      rounded = {1'b0, prev_end_r} + {2'b00, align_r} - {2'b00, mod_rsp.rem};
    end
  end

  assign fit_end = {1'b0, cand_r} + {3'b000, size_r};

  // request sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    j_nxt        = j_r;
    wr_nxt       = wr_r;
    hit_nxt      = hit_r;
    kind_nxt     = kind_r;
    size_nxt     = size_r;
    align_nxt    = align_r;
    foff_nxt     = foff_r;
    prev_end_nxt = prev_end_r;
    cand_nxt     = cand_r;
    res_nxt      = res_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt = out_data_r;
    mem_we       = 1'b0;
    mem_waddr    = j_r[AW-1:0];
    mem_wdata    = mem_rdata;
    mem_raddr    = idx_r[AW-1:0];
    mod_req.start    = 1'b0;
    mod_req.dividend = prev_end_r;
    mod_req.divisor  = align_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt     = in_data.kind;
          size_nxt     = in_data.req_size;
          align_nxt    = (in_data.req_align == 32'd0) ? 32'd1 : in_data.req_align;
          foff_nxt     = in_data.free_offset;
          idx_nxt      = '0;
          wr_nxt       = '0;
          hit_nxt      = 1'b0;
          prev_end_nxt = '0;
          if (in_data.kind == ffsa_pkg::KIND_FREE) begin
            state_nxt = S_FRD;
          end else if (count_r >= MAXC) begin
            res_nxt   = '{status: ffsa_pkg::ST_FULL, part_offset: 32'd0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RND;
          end
        end
      end
      S_RND: begin
        mod_req.start = 1'b1;
        state_nxt     = S_MODW;
      end
      S_MODW: begin
        if (mod_rsp.done) begin
          cand_nxt = rounded;
          if (idx_r < count_r) begin
            state_nxt = S_CMP;
          end else if ({1'b0, rounded} + {3'b000, size_r} <= {3'b000, cap_r}) begin
            pos_nxt   = count_r;
            j_nxt     = count_r;
            state_nxt = S_INS;
          end else begin
            res_nxt   = '{status: ffsa_pkg::ST_NO_SPACE, part_offset: 32'd0};
            state_nxt = S_DONE;
          end
        end
      end
      S_CMP: begin
        if (fit_end <= {3'b000, mem_rdata.offset}) begin
          pos_nxt   = idx_r;
          j_nxt     = count_r;
          state_nxt = S_SHR;
        end else begin
          prev_end_nxt = {1'b0, mem_rdata.offset} + {1'b0, mem_rdata.size};
          idx_nxt      = idx_r + CW'(1);
          state_nxt    = S_RND;
        end
      end
      // move entries above the insert point up by one, top first
      S_SHR: begin
        mem_raddr = AW'(j_r - CW'(1));
        state_nxt = (j_r > pos_r) ? S_SHW : S_INS;
      end
      S_SHW: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[AW-1:0];
        mem_wdata = mem_rdata;
        j_nxt     = j_r - CW'(1);
        state_nxt = S_SHR;
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[AW-1:0];
        mem_wdata = '{offset: cand_r[31:0], size: size_r};
        count_nxt = count_r + CW'(1);
        res_nxt   = '{status: ffsa_pkg::ST_OK, part_offset: cand_r[31:0]};
        state_nxt = S_DONE;
      end
      // free: compact the table, dropping every matching part
      S_FRD: begin
        if (idx_r == count_r) begin
          count_nxt = wr_r;
          res_nxt   = '{status: hit_r ? ffsa_pkg::ST_OK : ffsa_pkg::ST_NOT_FOUND,
                        part_offset: 32'd0};
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FCK;
        end
      end
      S_FCK: begin
        if (mem_rdata.offset == foff_r && mem_rdata.size == size_r) begin
          hit_nxt = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = wr_r[AW-1:0];
          mem_wdata = mem_rdata;
          wr_nxt    = wr_r + CW'(1);
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_FRD;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= 32'hFFFF_FFFF;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    j_r        <= j_nxt;
    wr_r       <= wr_nxt;
    hit_r      <= hit_nxt;
    kind_r     <= kind_nxt;
    size_r     <= size_nxt;
    align_r    <= align_nxt;
    foff_r     <= foff_nxt;
    prev_end_r <= prev_end_nxt;
    cand_r     <= cand_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // part count never exceeds the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAXC)
    else $error("part count above table depth");

  // a new result beat comes only out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result beat without finished request");

  // an accepted beat always leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r != S_IDLE)
    else $error("accepted beat not started");

  // table writes only happen while a request is in flight
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_SHW || state_r == S_INS || state_r == S_FCK))
    else $error("table write outside request");

endmodule

>>> verif/testbench.sv
// self-checking testbench for first_fit_aligned_suballocator
// depends on ffsa_pkg and the rtl top level; predicts each reply from its own part table
module testbench;

  localparam int NPARTS = 64;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int HOLD_CYCLES = 3000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ffsa_pkg::req_t in_data;
  logic out_valid;
  logic out_stall;
  ffsa_pkg::rsp_t out_data;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  first_fit_aligned_suballocator #(.MAX_PARTS(NPARTS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [31:0] capacity_q;
  logic [31:0] part_off [NPARTS];
  logic [31:0] part_sz [NPARTS];
  int part_cnt;
  ffsa_pkg::rsp_t expected_replies[$];
  int error_count = 0;
  int cycle_count = 0;
  bit hold_tog = 1'b0;
  bit hold_seen;
  int hold_left;
  bit burst_mode;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [33:0] round_up_to(logic [33:0] v, logic [33:0] a);
    logic [33:0] r;
    if (v == 0) return 0;
    r = v % a;
    if (r == 0) return v;
    return v + (a - r);
  endfunction

  // model one request: update the table and return the reply
  function automatic ffsa_pkg::rsp_t predict_reply(ffsa_pkg::req_t rq);
    ffsa_pkg::rsp_t rs;
    logic [33:0] a;
    logic [33:0] prev_end;
    logic [33:0] cand;
    int pos;
    int wr;
    bit hit;
    rs = '0;
    if (rq.kind == ffsa_pkg::KIND_ALLOC) begin
      a = (rq.req_align == 0) ? 34'd1 : {2'b0, rq.req_align};
      if (part_cnt >= NPARTS) begin
        rs.status = ffsa_pkg::ST_FULL;
        return rs;
      end
      prev_end = 0;
      pos = -1;
      for (int i = 0; i < part_cnt && pos < 0; i++) begin
        cand = round_up_to(prev_end, a);
        if (cand + rq.req_size <= {2'b0, part_off[i]}) pos = i;
        else prev_end = part_off[i] + {2'b0, part_sz[i]};
      end
      if (pos < 0) begin
        cand = round_up_to(prev_end, a);
        if (cand + rq.req_size <= {2'b0, capacity_q}) pos = part_cnt;
      end
      if (pos < 0) begin
        rs.status = ffsa_pkg::ST_NO_SPACE;
        return rs;
      end
      for (int i = part_cnt; i > pos; i--) begin
        part_off[i] = part_off[i-1];
        part_sz[i] = part_sz[i-1];
      end
      part_off[pos] = cand[31:0];
      part_sz[pos] = rq.req_size;
      part_cnt++;
      rs.status = ffsa_pkg::ST_OK;
      rs.part_offset = cand[31:0];
    end else begin
      wr = 0;
      hit = 0;
      for (int i = 0; i < part_cnt; i++) begin
        if (part_off[i] == rq.free_offset && part_sz[i] == rq.req_size) hit = 1;
        else begin
          part_off[wr] = part_off[i];
          part_sz[wr] = part_sz[i];
          wr++;
        end
      end
      part_cnt = wr;
      rs.status = hit ? ffsa_pkg::ST_OK : ffsa_pkg::ST_NOT_FOUND;
    end
    return rs;
  endfunction

  // receiver stall pattern, with a long hold-off counted here when the test asks for one
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_tog;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (burst_mode) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // reply checker
  always @(posedge clk) begin
    ffsa_pkg::rsp_t exp_rs;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply status=%0d offset=%0h", $time,
                 out_data.status, out_data.part_offset);
        error_count++;
      end else begin
        exp_rs = expected_replies.pop_front();
        if (out_data.status !== exp_rs.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_rs.status,
                   out_data.status);
          error_count++;
        end
        if (out_data.part_offset !== exp_rs.part_offset) begin
          $display("%0t: offset expected %0h actual %0h", $time, exp_rs.part_offset,
                   out_data.part_offset);
          error_count++;
        end
      end
    end
  end

  // send one beat, predicting at acceptance
  task automatic send_request(ffsa_pkg::req_t rq);
    in_data = rq;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_replies = {expected_replies, predict_reply(rq)};
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // random gap between requests outside burst mode
  task automatic maybe_gap();
    if (!burst_mode && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_capacity(logic [31:0] v);
    wait_drained();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    capacity_q = v;
  endtask

  function automatic ffsa_pkg::req_t make_alloc(logic [31:0] sz, logic [31:0] al);
    ffsa_pkg::req_t rq;
    rq.kind = ffsa_pkg::KIND_ALLOC;
    rq.req_size = sz;
    rq.req_align = al;
    rq.free_offset = $urandom();
    return rq;
  endfunction

  function automatic ffsa_pkg::req_t make_free(logic [31:0] off, logic [31:0] sz);
    ffsa_pkg::req_t rq;
    rq.kind = ffsa_pkg::KIND_FREE;
    rq.req_size = sz;
    rq.req_align = $urandom();
    rq.free_offset = off;
    return rq;
  endfunction

  // free whatever the table holds so later phases start empty
  task automatic clear_table();
    while (part_cnt > 0) begin
      wait_drained();
      send_request(make_free(part_off[0], part_sz[0]));
    end
    wait_drained();
  endtask

  // directed extremes and special cases
  task automatic test_directed();
    send_request(make_free(32'h0, 32'h0));               // not found on empty table
    send_request(make_alloc(32'h0, 32'h0));              // zero size, zero align
    send_request(make_alloc(32'h10, 32'h0));
    send_request(make_alloc(32'h7, 32'h100));
    send_request(make_alloc(32'hFFFF_FFFF, 32'h1));      // no space
    send_request(make_alloc(32'h1, 32'hFFFF_FFFF));
    send_request(make_alloc(32'h1, 32'h8000_0000));
    send_request(make_free(32'h100, 32'h7));
    send_request(make_free(32'h100, 32'h7));             // second free misses
    send_request(make_alloc(32'h20, 32'h10));
    send_request(make_free(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    clear_table();
    send_request(make_alloc(32'hFFFF_FFFF, 32'h0));      // whole region
    send_request(make_alloc(32'h0, 32'h3));
    clear_table();
  endtask

  // capacity extremes, including zero and a shrink under live parts
  task automatic test_capacity();
    write_capacity(32'h1);
    send_request(make_alloc(32'h2, 32'h1));
    send_request(make_alloc(32'h1, 32'h1));
    send_request(make_alloc(32'h0, 32'h1));
    write_capacity(32'h0);
    send_request(make_alloc(32'h1, 32'h0));
    send_request(make_alloc(32'h0, 32'h0));
    clear_table();
    write_capacity(32'h1000);
    for (int i = 0; i < 4; i++) send_request(make_alloc(32'h100, 32'h40));
    write_capacity(32'h200);                             // parts above are kept
    send_request(make_alloc(32'h10, 32'h0));
    clear_table();
  endtask

  // fill to table full
  task automatic test_table_full();
    write_capacity(32'hFFFF_FFFF);
    for (int i = 0; i < NPARTS + 2; i++)
      send_request(make_alloc($urandom_range(0, 64), $urandom_range(0, 16)));
    clear_table();
  endtask

  // long receiver hold-off while sender keeps offering
  task automatic test_backpressure();
    hold_tog = ~hold_tog;
    for (int i = 0; i < 8; i++) send_request(make_alloc($urandom_range(1, 50), 4));
    wait_drained();
    clear_table();
  endtask

  // random traffic: mostly frees of live parts and small allocates
  task automatic test_random(int n);
    ffsa_pkg::req_t rq;
    int k;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) burst_mode = ~burst_mode;
      if (i % 350 == 175) begin
        case ($urandom_range(0, 2))
          0: write_capacity($urandom_range(1, 4096));
          1: write_capacity(32'hFFFF_FFFF);
          default: write_capacity($urandom());
        endcase
      end
      maybe_gap();
      k = $urandom_range(0, 9);
      if (k < 4 && part_cnt > 0) begin
        k = $urandom_range(0, part_cnt - 1);
        rq = make_free(part_off[k], part_sz[k]);
      end else if (k == 4) begin
        rq = make_free($urandom(), $urandom());
      end else if (k == 5) begin
        rq = make_alloc($urandom(), $urandom());
      end else begin
        rq = make_alloc($urandom_range(0, 300), $urandom_range(0, 64));
      end
      // pool model in flight: predictions follow acceptance order, so frees of
      // a part that gets removed first simply report a miss
      send_request(rq);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    burst_mode = 1'b0;
    capacity_q = 32'hFFFF_FFFF;
    part_cnt = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_capacity();
    test_table_full();
    test_backpressure();
    test_random(1200);
    wait_drained();
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
